>>> src/b128e_pkg.sv
// shared types and constants for the base-128 stream encoder
// no dependencies; used by front, queue, back and top level
`timescale 1ns / 1ps

package b128e_pkg;

	// code layout
	localparam int CODE_W     = 8;
	localparam int PAYLOAD_W  = 7;
	localparam int RESIDUE_W  = 6;
	localparam int COUNT_W    = 3;
	localparam int ACC_W      = RESIDUE_W + CODE_W;
	localparam int SHIFT_W    = 4;

	// top bit forced on every code
	localparam logic CODE_MARK = 1'b1;

	// residue count at which the next byte leaves a full seven bits
	localparam logic [COUNT_W-1:0] CNT_FULL = COUNT_W'(PAYLOAD_W - 1);

	// decoupling queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one classified byte: first code, optional second code
	typedef struct packed {
		logic [PAYLOAD_W-1:0] c0;
		logic [PAYLOAD_W-1:0] c1;
		logic                 two;
		logic                 eom;
	} entry_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic   valid;
		entry_t data;
	} head_t;

endpackage

>>> src/b128e_front.sv
// front end: accepts bytes, updates the bit residue and splits into codes
// depends on b128e_pkg
`timescale 1ns / 1ps

module b128e_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [7:0]               data_byte,
	input  logic                     is_final,
	input  logic                     q_full,
	output logic                     in_stall,
	output logic                     push,
	output b128e_pkg::entry_t        push_data
);

	logic [b128e_pkg::RESIDUE_W-1:0] res_q;
	logic [b128e_pkg::COUNT_W-1:0]   cnt_q;

	logic [b128e_pkg::COUNT_W-1:0]   cnt_eff;
	logic [b128e_pkg::ACC_W-1:0]     acc;
	logic [b128e_pkg::ACC_W-1:0]     rem_mask;
	logic [b128e_pkg::SHIFT_W-1:0]   sh;
	logic [b128e_pkg::SHIFT_W-1:0]   pad_sh;
	logic [b128e_pkg::PAYLOAD_W-1:0] rem7;
	logic                            seven;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// split the accumulated bits into one or two codes
	always_comb begin
		cnt_eff  = (cnt_q > b128e_pkg::CNT_FULL) ? b128e_pkg::CNT_FULL : cnt_q;
		acc      = {res_q, data_byte};
		sh       = b128e_pkg::SHIFT_W'(cnt_eff) + b128e_pkg::SHIFT_W'(1);
		rem_mask = (b128e_pkg::ACC_W'(1) << sh) - b128e_pkg::ACC_W'(1);
		rem7     = b128e_pkg::PAYLOAD_W'(acc & rem_mask);
		pad_sh   = b128e_pkg::SHIFT_W'(b128e_pkg::PAYLOAD_W) - sh;
		seven    = (cnt_eff == b128e_pkg::CNT_FULL);
		push_data.c0  = b128e_pkg::PAYLOAD_W'(acc >> sh);
		push_data.c1  = seven ? rem7 : b128e_pkg::PAYLOAD_W'(rem7 << pad_sh);
		push_data.two = seven || is_final;
		push_data.eom = is_final;
	end

	// residue state, updated on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			cnt_q <= '0;
		end else if (push) begin
			if (push_data.two) begin
				res_q <= '0;
				cnt_q <= '0;
			end else begin
				res_q <= rem7[b128e_pkg::RESIDUE_W-1:0];
				cnt_q <= sh[b128e_pkg::COUNT_W-1:0];
			end
		end
	end

endmodule

>>> src/b128e_queue.sv
// small fifo of classified entries between front and back
// depends on b128e_pkg
`timescale 1ns / 1ps

module b128e_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  b128e_pkg::entry_t        push_data,
	input  logic                     pop,
	output logic                     full,
	output b128e_pkg::head_t         head
);

	b128e_pkg::entry_t               mem_q [b128e_pkg::QDEPTH];
	logic [b128e_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [b128e_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [b128e_pkg::QCNT_W-1:0]    cnt_q;
	logic                            do_pop;

	assign full       = (cnt_q == b128e_pkg::QCNT_W'(b128e_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.data  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == b128e_pkg::QPTR_W'(b128e_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + b128e_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == b128e_pkg::QPTR_W'(b128e_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + b128e_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + b128e_pkg::QCNT_W'(push && !full)
				- b128e_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

>>> src/b128e_back.sv
// back end: sends the one or two codes of each entry through the output register
// depends on b128e_pkg
`timescale 1ns / 1ps

module b128e_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  b128e_pkg::head_t                    head,
	input  logic                                out_stall,
	output logic                                pop,
	output logic                                out_valid,
	output logic [b128e_pkg::CODE_W-1:0]        code_byte,
	output logic                                end_of_message
);

	logic                            out_valid_q;
	logic [b128e_pkg::CODE_W-1:0]    code_q;
	logic                            eom_q;
	logic                            half_q;
	logic                            load;
	logic                            last;

	assign out_valid      = out_valid_q;
	assign code_byte      = code_q;
	assign end_of_message = eom_q;

	// output register free, or its transfer happens now
	assign load = !out_valid_q || !out_stall;
	assign last = !head.data.two || half_q;
	assign pop  = load && head.valid && last;

	// output register and second-code phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (load) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				half_q <= head.data.two && !half_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			code_q <= {b128e_pkg::CODE_MARK, half_q ? head.data.c1 : head.data.c0};
			eom_q  <= head.data.eom && last;
		end
	end

endmodule

>>> src/base128_stream_encoder_core.sv
// path: a byte's codes go into a queue entry, then into the output register
// throughput: one byte per cycle when it yields one code and out_stall is low; a
// two-code byte holds the queue head; the single-code output register sends both
// a two-entry queue lets the front accept bytes while the output is stalled, until full
// reset: arst_n clears the residue, the queue and the output valid at once
`timescale 1ns / 1ps

module base128_stream_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code_byte,
	output logic       end_of_message
);

	logic              push;
	b128e_pkg::entry_t push_data;
	logic              q_full;
	logic              pop;
	b128e_pkg::head_t  head;

	// front: residue and code split
	b128e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.is_final  (is_final),
		.q_full    (q_full),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	b128e_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	// back: code output
	b128e_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.out_stall      (out_stall),
		.pop            (pop),
		.out_valid      (out_valid),
		.code_byte      (code_byte),
		.end_of_message (end_of_message)
	);

endmodule

>>> src/b128e_checker.sv
// port-level checks for the base-128 stream encoder
// depends only on the top-level ports; bound to base128_stream_encoder_core
`timescale 1ns / 1ps

module b128e_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       is_final,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] code_byte,
	input logic       end_of_message
);

	// every code carries the top-bit mark
	a_code_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> code_byte[7])
		else $error("code without top bit");

	// a stalled code holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_byte) && $stable(end_of_message))
		else $error("stalled code changed");

	// output comes alive only after an input transfer has passed through the queue
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("code without a byte transfer");

endmodule

bind base128_stream_encoder_core b128e_checker u_b128e_checker (.*);

>>> dv/base128_stream_encoder_core_tb.sv
// self-checking testbench for base128_stream_encoder_core
// depends on src/b128e_pkg.sv and src/base128_stream_encoder_core.sv
`timescale 1ns / 1ps

module base128_stream_encoder_core_tb;

	// cycles without any transfer before the run is declared hung
	localparam int IDLE_LIMIT  = 2000;
	// length of the long receiver hold-off in the pressure phase
	localparam int LONG_HOLD   = 200;
	// least number of random bytes offered per phase
	localparam int PHASE_BYTES = 240;
	localparam int NUM_PHASES  = 5;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} raw_byte_t;

	typedef struct {
		logic [b128e_pkg::CODE_W-1:0] code;
		logic                         eom;
	} code_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       is_final = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] code_byte;
	logic       end_of_message;

	// bytes waiting to be offered and codes waiting to come out
	raw_byte_t raw_q[$];
	code_t     code_q[$];

	// encoder state as predicted by the testbench
	logic [b128e_pkg::RESIDUE_W-1:0] pend_bits = '0;
	logic [b128e_pkg::COUNT_W-1:0]   pend_cnt = '0;

	raw_byte_t next_byte;
	code_t     want;
	int        send_idle_pct = 0;
	int        stall_pct = 0;
	bit        hold_req = 1'b0;
	bit        hold_taken = 1'b0;
	int        hold_cnt = 0;
	bit        byte_taken = 1'b0;
	bit        code_taken = 1'b0;
	int        idle_run = 0;
	int        err_cnt = 0;

	base128_stream_encoder_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.is_final       (is_final),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code_byte      (code_byte),
		.end_of_message (end_of_message)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// append one byte's bits to the residue and queue the codes it yields
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		int                              acc;
		int                              nbits;
		int                              k;
		logic [b128e_pkg::PAYLOAD_W-1:0] pay[2];
		code_t                           c;
		acc = int'({pend_bits, b});
		nbits = int'(pend_cnt) + 8;
		pay[0] = b128e_pkg::PAYLOAD_W'(acc >> (nbits - b128e_pkg::PAYLOAD_W));
		k = 1;
		nbits -= b128e_pkg::PAYLOAD_W;
		acc &= (1 << nbits) - 1;
		// a full seven bits left over go out right away
		if (nbits == b128e_pkg::PAYLOAD_W) begin
			pay[1] = b128e_pkg::PAYLOAD_W'(acc);
			k = 2;
			nbits = 0;
			acc = 0;
		end
		// flush leftover bits left-aligned on the last byte
		if (fin && nbits > 0) begin
			pay[k] = b128e_pkg::PAYLOAD_W'(acc << (b128e_pkg::PAYLOAD_W - nbits));
			k++;
			nbits = 0;
			acc = 0;
		end
		for (int i = 0; i < k; i++) begin
			c.code = {b128e_pkg::CODE_MARK, pay[i]};
			c.eom = fin && (i == k - 1);
			code_q.push_back(c);
		end
		pend_bits = b128e_pkg::RESIDUE_W'(acc);
		pend_cnt = b128e_pkg::COUNT_W'(nbits);
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic fin);
		raw_byte_t r;
		r.data = b;
		r.fin = fin;
		raw_q.push_back(r);
	endtask

	// message of random bytes, extremes mixed in now and then
	task automatic queue_message(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: b = 8'h00;
				1: b = 8'hff;
				default: b = 8'($urandom_range(255));
			endcase
			queue_byte(b, i == len - 1);
		end
	endtask

	// sample transfers, predict on input, check on output
	always @(posedge clk) begin
		byte_taken = arst_n && in_valid && !in_stall;
		code_taken = arst_n && out_valid && !out_stall;
		if (byte_taken)
			encode_byte(data_byte, is_final);
		if (code_taken) begin
			if (code_q.size() == 0) begin
				$error("unexpected code transfer: code_byte %h end_of_message %b",
					code_byte, end_of_message);
				err_cnt++;
			end else begin
				want = code_q.pop_front();
				if (code_byte !== want.code) begin
					$error("code_byte: expected %h, got %h", want.code, code_byte);
					err_cnt++;
				end
				if (end_of_message !== want.eom) begin
					$error("end_of_message: expected %b, got %b", want.eom,
						end_of_message);
					err_cnt++;
				end
			end
		end
		if (byte_taken || code_taken)
			idle_run = 0;
		else
			idle_run++;
	end

	// byte driver: holds an offered byte until its transfer
	always @(negedge clk) begin
		if (arst_n && (!in_valid || byte_taken)) begin
			if (raw_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_byte = raw_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_byte.data;
				is_final <= next_byte.fin;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// code receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_cnt = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with no transfer at all
	initial begin
		wait (idle_run >= IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int added;
		int len;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: one-byte messages at both extremes
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hff, 1'b1);
		// seven ones bytes: residue reaches seven bits, final with empty residue
		for (int i = 0; i < 7; i++)
			queue_byte(8'hff, i == 6);
		// eight bytes: a full group then a one-bit flush
		for (int i = 0; i < 8; i++)
			queue_byte((i % 2) ? 8'h01 : 8'h80, i == 7);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 75; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 75; end
				3: begin send_idle_pct = 6;  stall_pct = 6;  end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			added = 0;
			while (added < PHASE_BYTES) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) :
					$urandom_range(16, 1);
				queue_message(len);
				added += len;
			end
			while (raw_q.size() != 0 || in_valid)
				@(posedge clk);
		end

		while (code_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
